/* rtl/ptx_pkg.sv */
// shared constants, types and helpers of the point transform
// no dependencies
package ptx_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CFG_W         = 64;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned ADDR_W        = 6;
  // row sum: three 64-bit products plus the translation, with headroom
  localparam int unsigned SUM_W         = 67;
  // quotient bits: 32 result bits plus one overflow bit
  localparam int unsigned QUO_W         = 33;
  localparam int unsigned LANES         = 3;

  localparam logic [2:0] REG_X_AB = 3'd0;
  localparam logic [2:0] REG_X_CD = 3'd1;
  localparam logic [2:0] REG_Y_AB = 3'd2;
  localparam logic [2:0] REG_Y_CD = 3'd3;
  localparam logic [2:0] REG_Z_AB = 3'd4;
  localparam logic [2:0] REG_Z_CD = 3'd5;
  localparam logic [2:0] REG_W_AB = 3'd6;
  localparam logic [2:0] REG_W_CD = 3'd7;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic             w_one;
    logic             w_zero;
    logic [LANES-1:0] neg;
  } ptx_ctrl_t;

  // saturate a signed row-width value to 32 bits
  function automatic logic [DATA_W-1:0] sat_sum(input logic [SUM_W-1:0] v);
    logic fits;
    fits = (v[SUM_W-1:DATA_W-1] == '0) || (v[SUM_W-1:DATA_W-1] == '1);
    if (fits) begin
      sat_sum = v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_sum = SAT_MIN;
    end else begin
      sat_sum = SAT_MAX;
    end
  endfunction

endpackage

/* rtl/ptx_rows.sv */
// front end: products, row sums and divider setup, three register stages
// depends on ptx_pkg
module ptx_rows #(
  parameter int unsigned FRAC_BITS = ptx_pkg::FRAC_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             vld_i,
  input  logic [ptx_pkg::LANES-1:0][ptx_pkg::DATA_W-1:0]   pt_i,
  input  logic [ptx_pkg::NUM_REGS-1:0][ptx_pkg::CFG_W-1:0] cfg_i,
  output logic                                             vld_o,
  output ptx_pkg::ptx_ctrl_t                               ctrl_o,
  output logic [ptx_pkg::SUM_W+FRAC_BITS+ptx_pkg::QUO_W-1:0] div_o,
  output logic [ptx_pkg::LANES-1:0][ptx_pkg::SUM_W+FRAC_BITS+ptx_pkg::QUO_W-1:0] num_o,
  output logic [ptx_pkg::LANES-1:0][ptx_pkg::DATA_W-1:0]   alt_o
);

  localparam int unsigned SW = ptx_pkg::SUM_W;
  localparam int unsigned CW = SW + FRAC_BITS + ptx_pkg::QUO_W;
  localparam int unsigned DW = ptx_pkg::DATA_W;
  localparam int unsigned PW = 2 * DW;

  // stage 1: products and shifted translation
  logic [3:0][2:0][PW-1:0] prod_d, prod_q;
  logic [3:0][SW-1:0]      tsh_d, tsh_q;
  logic                    v1_q, v2_q, v3_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      logic [DW-1:0] c0, c1, c2, t;
      c0 = cfg_i[2*r][DW-1:0];
      c1 = cfg_i[2*r][PW-1:DW];
      c2 = cfg_i[2*r+1][DW-1:0];
      t  = cfg_i[2*r+1][PW-1:DW];
      prod_d[r][0] = PW'($signed(pt_i[0]) * $signed(c0));
      prod_d[r][1] = PW'($signed(pt_i[1]) * $signed(c1));
      prod_d[r][2] = PW'($signed(pt_i[2]) * $signed(c2));
      tsh_d[r] = SW'($signed({{(SW-DW){t[DW-1]}}, t}) <<< FRAC_BITS);
    end
  end

  // stage 2: row sums
  logic [3:0][SW-1:0] sum_d, sum_q;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_d[r] = {{(SW-PW){prod_q[r][0][PW-1]}}, prod_q[r][0]}
               + {{(SW-PW){prod_q[r][1][PW-1]}}, prod_q[r][1]}
               + {{(SW-PW){prod_q[r][2][PW-1]}}, prod_q[r][2]}
               + tsh_q[r];
    end
  end

  // stage 3: magnitudes, special cases of w
  ptx_pkg::ptx_ctrl_t                       ctrl_d;
  logic [CW-1:0]                            div_d;
  logic [ptx_pkg::LANES-1:0][CW-1:0]        num_d;
  logic [ptx_pkg::LANES-1:0][DW-1:0]        alt_d;

  always_comb begin
    logic [SW-1:0] w, aw;
    w  = sum_q[3];
    aw = w[SW-1] ? (~w + SW'(1)) : w;
    div_d         = CW'(aw);
    ctrl_d.w_one  = (w == (SW'(1) << (2 * FRAC_BITS)));
    ctrl_d.w_zero = (w == '0);
    for (int k = 0; k < ptx_pkg::LANES; k++) begin
      logic [SW-1:0] s, as, sh;
      s  = sum_q[k];
      as = s[SW-1] ? (~s + SW'(1)) : s;
      sh = SW'($signed(s) >>> FRAC_BITS);
      ctrl_d.neg[k] = s[SW-1] ^ w[SW-1];
      num_d[k]      = CW'(as) << FRAC_BITS;
      if (ctrl_d.w_one) begin
        alt_d[k] = ptx_pkg::sat_sum(sh);
      end else if (s == '0) begin
        alt_d[k] = '0;
      end else if (s[SW-1]) begin
        alt_d[k] = ptx_pkg::SAT_MIN;
      end else begin
        alt_d[k] = ptx_pkg::SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      tsh_q  <= tsh_d;
      sum_q  <= sum_d;
      ctrl_o <= ctrl_d;
      div_o  <= div_d;
      num_o  <= num_d;
      alt_o  <= alt_d;
    end
  end

  assign vld_o = v3_q;

endmodule

/* rtl/ptx_div_cell.sv */
// one restoring divide step for three lanes sharing a divisor
// depends on ptx_pkg
module ptx_div_cell #(
  parameter int unsigned CW  = 116,
  parameter int unsigned BIT = 0
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           en_i,
  input  logic                                           vld_i,
  input  ptx_pkg::ptx_ctrl_t                             ctrl_i,
  input  logic [CW-1:0]                                  div_i,
  input  logic [ptx_pkg::LANES-1:0][CW-1:0]              rem_i,
  input  logic [ptx_pkg::LANES-1:0][ptx_pkg::QUO_W-1:0]  quo_i,
  input  logic [ptx_pkg::LANES-1:0][ptx_pkg::DATA_W-1:0] alt_i,
  output logic                                           vld_o,
  output ptx_pkg::ptx_ctrl_t                             ctrl_o,
  output logic [CW-1:0]                                  div_o,
  output logic [ptx_pkg::LANES-1:0][CW-1:0]              rem_o,
  output logic [ptx_pkg::LANES-1:0][ptx_pkg::QUO_W-1:0]  quo_o,
  output logic [ptx_pkg::LANES-1:0][ptx_pkg::DATA_W-1:0] alt_o
);

  logic [CW-1:0]                                 dsh;
  logic [ptx_pkg::LANES-1:0][CW-1:0]             rem_d;
  logic [ptx_pkg::LANES-1:0][ptx_pkg::QUO_W-1:0] quo_d;

  assign dsh = div_i << BIT;

  always_comb begin
    for (int k = 0; k < ptx_pkg::LANES; k++) begin
      rem_d[k] = rem_i[k];
      quo_d[k] = quo_i[k];
      if (rem_i[k] >= dsh) begin
        rem_d[k]      = rem_i[k] - dsh;
        quo_d[k][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrl_o <= ctrl_i;
      div_o  <= div_i;
      rem_o  <= rem_d;
      quo_o  <= quo_d;
      alt_o  <= alt_i;
    end
  end

endmodule

/* rtl/point_transform_4x4.sv */
// point_transform_4x4: 4x4 homogeneous transform of a fixed-point 3d point
// pipeline of 3 front-end stages, 33 divide cells and 1 output register
// throughput one item per cycle; the whole pipe holds while the output stalls
// reset clears the valid bits and loads the identity transform
// depends on ptx_pkg, ptx_rows, ptx_div_cell
module point_transform_4x4 #(
  parameter int unsigned FRAC_BITS = ptx_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input items
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [95:0]                 s_axis_tdata,  // in_x, in_y, in_z
  // result items
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [95:0]                 m_axis_tdata,  // out_x, out_y, out_z
  output logic [1:0]                  m_axis_tuser,  // was_divided, w_was_zero
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ptx_pkg::ADDR_W-1:0]  paddr,
  input  logic [ptx_pkg::CFG_W-1:0]   pwdata,
  output logic [ptx_pkg::CFG_W-1:0]   prdata,
  output logic                        pready
);

  localparam int unsigned DW    = ptx_pkg::DATA_W;
  localparam int unsigned QW    = ptx_pkg::QUO_W;
  localparam int unsigned LN    = ptx_pkg::LANES;
  localparam int unsigned CW    = ptx_pkg::SUM_W + FRAC_BITS + QW;
  localparam int unsigned NCELL = QW;
  localparam logic [ptx_pkg::CFG_W-1:0] ONE_LO = ptx_pkg::CFG_W'(1) << FRAC_BITS;
  localparam logic [ptx_pkg::CFG_W-1:0] ONE_HI = ONE_LO << DW;

  // identity transform as register contents
  function automatic logic [ptx_pkg::NUM_REGS-1:0][ptx_pkg::CFG_W-1:0] cfg_reset();
    cfg_reset                    = '0;
    cfg_reset[ptx_pkg::REG_X_AB] = ONE_LO;
    cfg_reset[ptx_pkg::REG_Y_AB] = ONE_HI;
    cfg_reset[ptx_pkg::REG_Z_CD] = ONE_LO;
    cfg_reset[ptx_pkg::REG_W_CD] = ONE_HI;
  endfunction

  // register file, eight 64-bit words at 8-byte spacing
  logic [ptx_pkg::NUM_REGS-1:0][ptx_pkg::CFG_W-1:0] cfg_q;
  logic [2:0] widx;
  logic       wr_en;

  assign pready = 1'b1;
  assign widx   = paddr[5:3];
  assign wr_en  = psel & penable & pwrite;
  assign prdata = cfg_q[widx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= cfg_reset();
    end else if (wr_en) begin
      cfg_q[widx] <= pwdata;
    end
  end

  // pipe advances whenever the output register is free or being drained
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // front end
  logic [LN-1:0][DW-1:0] pt;
  assign pt[0] = s_axis_tdata[31:0];
  assign pt[1] = s_axis_tdata[63:32];
  assign pt[2] = s_axis_tdata[95:64];

  logic                       vld   [NCELL+1];
  ptx_pkg::ptx_ctrl_t         ctrl  [NCELL+1];
  logic [CW-1:0]              div   [NCELL+1];
  logic [LN-1:0][CW-1:0]      rem   [NCELL+1];
  logic [LN-1:0][QW-1:0]      quo   [NCELL+1];
  logic [LN-1:0][DW-1:0]      alt   [NCELL+1];

  ptx_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .pt_i   (pt),
    .cfg_i  (cfg_q),
    .vld_o  (vld[0]),
    .ctrl_o (ctrl[0]),
    .div_o  (div[0]),
    .num_o  (rem[0]),
    .alt_o  (alt[0])
  );

  assign quo[0] = '0;

  // chain of divide cells, top quotient bit first; bit 32 flags overflow
  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    ptx_div_cell #(.CW(CW), .BIT(NCELL - 1 - c)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[c]),
      .ctrl_i (ctrl[c]),
      .div_i  (div[c]),
      .rem_i  (rem[c]),
      .quo_i  (quo[c]),
      .alt_i  (alt[c]),
      .vld_o  (vld[c+1]),
      .ctrl_o (ctrl[c+1]),
      .div_o  (div[c+1]),
      .rem_o  (rem[c+1]),
      .quo_o  (quo[c+1]),
      .alt_o  (alt[c+1])
    );
  end

  // final select: sign, saturation, special cases of w
  ptx_pkg::ptx_ctrl_t    fc;
  logic [LN-1:0][DW-1:0] res;
  assign fc = ctrl[NCELL];

  always_comb begin
    for (int k = 0; k < LN; k++) begin
      logic [QW-1:0] q;
      q = quo[NCELL][k];
      if (fc.w_one || fc.w_zero) begin
        res[k] = alt[NCELL][k];
      end else if (fc.neg[k]) begin
        if (q[QW-1] || (q[DW-1] && (q[DW-2:0] != '0))) begin
          res[k] = ptx_pkg::SAT_MIN;
        end else begin
          res[k] = ~q[DW-1:0] + DW'(1);
        end
      end else begin
        if (q[QW-1] || q[DW-1]) begin
          res[k] = ptx_pkg::SAT_MAX;
        end else begin
          res[k] = q[DW-1:0];
        end
      end
    end
  end

  // output register
  logic [95:0] out_data_q;
  logic [1:0]  out_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {res[2], res[1], res[0]};
      out_user_q <= {fc.w_zero, !fc.w_one};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule
